// ===== rtl/sbh_pkg.sv =====
// shared types, constants and a helper function for the string bucket hash engine
// no dependencies
`default_nettype none

package sbh_pkg;

  localparam int WORD_W = 32;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;
  localparam int PROD_W = 25;
  localparam int STEP_W = $clog2(WORD_W);

  localparam logic [LEN_W-1:0]  MAX_KEY_LEN = 16'hFFFF;
  localparam logic [PROD_W-1:0] XOR_MULT    = 25'd271;
  localparam int                SHIFT_33    = 5;

  localparam logic [WORD_W-1:0] TABLE_SIZE_RESET = 32'd1024;

  localparam logic [1:0] MODE_WHOLE   = 2'd0;
  localparam logic [1:0] MODE_HALF    = 2'd1;
  localparam logic [1:0] MODE_TIMES33 = 2'd2;

  localparam logic REG_HASH_MODE  = 1'b0;
  localparam logic REG_TABLE_SIZE = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [WORD_W-1:0] hash;
  } sbh_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sbh_q_status_t;

  function automatic logic [PROD_W-1:0] times_xor_mult(input logic [LEN_W-1:0] x);
    return PROD_W'(x) * XOR_MULT;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sbh_fifo.sv =====
// short queue of finished key hashes between front and back
// depends on sbh_pkg
`default_nettype none

module sbh_fifo
  import sbh_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire sbh_job_t      push_job,
  input  wire logic          pop,
  output sbh_job_t           pop_job,
  output sbh_q_status_t      status
);

  sbh_job_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_job      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full)
    else $error("hash queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("hash queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/sbh_front.sv =====
// byte intake: running hash per key, final length term (whole and half modes), push to queue
// depends on sbh_pkg
`default_nettype none

module sbh_front
  import sbh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        hash_mode,
  input  wire logic              key_valid,
  output logic                   key_ready,
  input  wire logic [BYTE_W-1:0] key_byte,
  input  wire logic [LEN_W-1:0]  key_length,
  input  wire logic              last_byte,
  input  wire sbh_q_status_t     q_status,
  output logic                   push,
  output sbh_job_t               push_job
);

  logic [WORD_W-1:0] acc;
  logic [LEN_W-1:0]  pos;
  logic [WORD_W-1:0] acc_next;
  logic [LEN_W-1:0]  pos_next;
  logic [WORD_W-1:0] hash_final;
  logic [PROD_W-1:0] byte_prod;
  logic              accept;

  assign key_ready = !q_status.full;
  assign accept    = key_valid && key_ready;
  assign push      = accept && last_byte;
  assign byte_prod = times_xor_mult(LEN_W'(key_byte));
  assign pos_next  = (pos == MAX_KEY_LEN) ? pos : pos + 1'b1;

  always_comb begin
    case (hash_mode)
      MODE_WHOLE: begin
        acc_next   = acc ^ WORD_W'(byte_prod);
        hash_final = acc_next ^ WORD_W'(times_xor_mult(pos_next));
      end
      MODE_HALF: begin
        acc_next   = (pos >= (key_length >> 1)) ? (acc ^ WORD_W'(byte_prod)) : acc;
        hash_final = acc_next ^ WORD_W'(times_xor_mult(key_length));
      end
      default: begin
        acc_next   = (acc << SHIFT_33) + acc + WORD_W'(key_byte);
        hash_final = acc_next;
      end
    endcase
  end

  assign push_job.hash = hash_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      pos <= '0;
    end else if (accept) begin
      if (last_byte) begin
        acc <= '0;
        pos <= '0;
      end else begin
        acc <= acc_next;
        pos <= pos_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_pos_advances: assert property (@(posedge clk) disable iff (rst)
    (accept && !last_byte) |=> (pos != '0))
    else $error("byte position failed to advance inside a key");
`endif

endmodule

`default_nettype wire

// ===== rtl/sbh_back.sv =====
// bucket reduction: bit-serial restoring modulo and output register
// depends on sbh_pkg
`default_nettype none

module sbh_back
  import sbh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [WORD_W-1:0] table_size,
  input  wire sbh_q_status_t     q_status,
  input  wire sbh_job_t          pop_job,
  output logic                   pop,
  output logic                   bucket_valid,
  input  wire logic              bucket_ready,
  output logic [WORD_W-1:0]      bucket_index
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  state_t            state;
  logic [WORD_W-1:0] dvd;
  logic [WORD_W-1:0] div;
  logic [WORD_W-1:0] rem;
  logic [STEP_W-1:0] cnt;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic [WORD_W-1:0] rem_next;
  logic              out_free;

  assign pop      = (state == ST_IDLE) && !q_status.empty;
  assign out_free = !bucket_valid || bucket_ready;
  assign shifted  = {rem, dvd[WORD_W-1]};
  assign diff     = shifted - {1'b0, div};
  assign rem_next = diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      bucket_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop) begin
            dvd <= pop_job.hash;
            div <= table_size;
            cnt <= '0;
            if (table_size == '0) begin
              rem   <= pop_job.hash;
              state <= ST_FINISH;
            end else begin
              rem   <= '0;
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          rem <= rem_next;
          dvd <= dvd << 1;
          cnt <= cnt + 1'b1;
          if (cnt == STEP_W'(WORD_W - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            bucket_index <= rem;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (state == ST_FINISH && out_free) begin
        bucket_valid <= 1'b1;
      end else if (bucket_ready) begin
        bucket_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (rem < div))
    else $error("partial remainder not below divisor");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> (bucket_valid && state == ST_IDLE))
    else $error("finished result not loaded into output register");
`endif

endmodule

`default_nettype wire

// ===== rtl/string_bucket_hash_engine_top.sv =====
// string bucket hash engine top level: config registers, front, queue, back
// depends on sbh_pkg, sbh_front, sbh_fifo, sbh_back
//
//  channel   signals                                         dir
//  key       key_valid key_ready key_byte key_length last_byte in
//  bucket    bucket_valid bucket_ready bucket_index          out
//  cfg       cfg_we cfg_index cfg_data                       in
//
// key bytes are taken one per cycle while key_ready is high; the running hash updates in the same cycle
// a key's last byte queues its hash; the back end reduces one hash at a time (load, bit-serial
// modulo, output), so a stream of short keys can fill the queue
// key_ready drops only while the two-entry queue is full
// synchronous reset clears mode to 0, table size to 1024 and all control state
`default_nettype none

module string_bucket_hash_engine_top
  import sbh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              key_valid,
  output logic                   key_ready,
  input  wire logic [BYTE_W-1:0] key_byte,
  input  wire logic [LEN_W-1:0]  key_length,
  input  wire logic              last_byte,
  output logic                   bucket_valid,
  input  wire logic              bucket_ready,
  output logic [WORD_W-1:0]      bucket_index,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [WORD_W-1:0] cfg_data
);

  logic [1:0]        hash_mode;
  logic [WORD_W-1:0] table_size;
  logic              push;
  logic              pop;
  sbh_job_t          push_job;
  sbh_job_t          pop_job;
  sbh_q_status_t     q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mode  <= MODE_WHOLE;
      table_size <= TABLE_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HASH_MODE:  hash_mode  <= cfg_data[1:0];
        REG_TABLE_SIZE: table_size <= cfg_data;
        default:        hash_mode  <= hash_mode;
      endcase
    end
  end

  sbh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .hash_mode  (hash_mode),
    .key_valid  (key_valid),
    .key_ready  (key_ready),
    .key_byte   (key_byte),
    .key_length (key_length),
    .last_byte  (last_byte),
    .q_status   (q_status),
    .push       (push),
    .push_job   (push_job)
  );

  sbh_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  sbh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .table_size   (table_size),
    .q_status     (q_status),
    .pop_job      (pop_job),
    .pop          (pop),
    .bucket_valid (bucket_valid),
    .bucket_ready (bucket_ready),
    .bucket_index (bucket_index)
  );

endmodule

`default_nettype wire

// ===== tb/sv/string_bucket_hash_engine_top_tb.sv =====
// self-checking testbench for string_bucket_hash_engine_top: streams keys byte by byte
// and checks each bucket index against an in-bench hash predictor
// depends on sbh_pkg and the engine rtl
module string_bucket_hash_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbh_pkg::*;

  localparam logic [1:0]        MODE_UNUSED   = 2'd3;
  localparam logic [WORD_W-1:0] MULT271       = WORD_W'(XOR_MULT);
  localparam int                SETTLE_CYCLES = 40;
  localparam int                CYCLE_LIMIT   = 1000000;

  logic              clk;
  logic              rst;
  logic              key_valid;
  logic              key_ready;
  logic [BYTE_W-1:0] key_byte;
  logic [LEN_W-1:0]  key_length;
  logic              last_byte;
  logic              bucket_valid;
  logic              bucket_ready = 1'b0;
  logic [WORD_W-1:0] bucket_index;
  logic              cfg_we;
  logic              cfg_index;
  logic [WORD_W-1:0] cfg_data;

  logic [1:0]        cur_mode;
  logic [WORD_W-1:0] cur_table_size;
  logic [WORD_W-1:0] run_hash;
  logic [LEN_W-1:0]  run_count;
  logic [WORD_W-1:0] expected_buckets[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int items_sent  = 0;
  int errors      = 0;
  int cycle_count = 0;

  string_bucket_hash_engine_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .key_valid    (key_valid),
    .key_ready    (key_ready),
    .key_byte     (key_byte),
    .key_length   (key_length),
    .last_byte    (last_byte),
    .bucket_valid (bucket_valid),
    .bucket_ready (bucket_ready),
    .bucket_index (bucket_index),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("string_bucket_hash_engine_top_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    bucket_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin : check_buckets
    logic [WORD_W-1:0] want;
    if (!rst && bucket_valid && bucket_ready) begin
      if (expected_buckets.size() == 0) begin
        $display("%0t: unexpected bucket_index, expected none, actual %08h",
                 $time, bucket_index);
        errors++;
      end else begin
        want = expected_buckets.pop_front();
        if (bucket_index !== want) begin
          $display("%0t: bucket_index mismatch, expected %08h, actual %08h",
                   $time, want, bucket_index);
          errors++;
        end
      end
    end
  end

  // running hash per accepted item; queues the bucket on the last byte
  function automatic void hash_key_byte(input logic [BYTE_W-1:0] b,
                                        input logic [LEN_W-1:0] len,
                                        input logic last);
    logic [WORD_W-1:0] h;
    logic [LEN_W-1:0]  cnt;
    case (cur_mode)
      MODE_WHOLE: h = run_hash ^ (MULT271 * WORD_W'(b));
      MODE_HALF:  h = (run_count >= (len >> 1)) ? (run_hash ^ (MULT271 * WORD_W'(b)))
                                                : run_hash;
      default:    h = (run_hash << SHIFT_33) + run_hash + WORD_W'(b);
    endcase
    cnt = (run_count < MAX_KEY_LEN) ? run_count + 1'b1 : run_count;
    if (!last) begin
      run_hash  = h;
      run_count = cnt;
    end else begin
      if (cur_mode == MODE_WHOLE)
        h = h ^ (MULT271 * WORD_W'(cnt));
      else if (cur_mode == MODE_HALF)
        h = h ^ (MULT271 * WORD_W'(len));
      if (cur_table_size != '0)
        h = h % cur_table_size;
      expected_buckets.push_back(h);
      run_hash  = '0;
      run_count = '0;
    end
  endfunction

  task automatic send_key_byte(input logic [BYTE_W-1:0] b, input logic [LEN_W-1:0] len,
                               input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      key_valid <= 1'b0;
      @(posedge clk);
    end
    key_valid  <= 1'b1;
    key_byte   <= b;
    key_length <= len;
    last_byte  <= last;
    @(posedge clk);
    while (!key_ready) @(posedge clk);
    hash_key_byte(b, len, last);
    items_sent++;
  endtask

  task automatic send_key(input logic [BYTE_W-1:0] bytes[$], input logic [LEN_W-1:0] len);
    foreach (bytes[i])
      send_key_byte(bytes[i], len, i == bytes.size() - 1);
  endtask

  task automatic drain();
    key_valid <= 1'b0;
    while (expected_buckets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] mode, input logic [WORD_W-1:0] size);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HASH_MODE;
    cfg_data  <= {(WORD_W-2)'($urandom), mode};
    @(posedge clk);
    cur_mode = mode;
    cfg_index <= REG_TABLE_SIZE;
    cfg_data  <= size;
    @(posedge clk);
    cur_table_size = size;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] pick_table_size();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3:       return TABLE_SIZE_RESET;
      4:       return 32'd1 << $urandom_range(31);
      5:       return WORD_W'($urandom_range(2, 4096));
      default: return WORD_W'($urandom);
    endcase
  endfunction

  task automatic send_random_key();
    int unsigned       n;
    int unsigned       pick;
    logic [LEN_W-1:0]  len_field;
    pick = $urandom_range(99);
    if (pick < 70)      n = $urandom_range(1, 12);
    else if (pick < 98) n = $urandom_range(13, 64);
    else                n = $urandom_range(65, 400);
    len_field = LEN_W'(n);
    pick = $urandom_range(99);
    if (pick < 10) len_field = LEN_W'($urandom);
    for (int unsigned i = 1; i <= n; i++) begin
      if (pick >= 95) len_field = LEN_W'($urandom);
      send_key_byte(BYTE_W'($urandom), len_field, i == n);
    end
  endtask

  // defaults after reset: whole-string mode, 1024 buckets
  task automatic test_reset_values();
    send_key('{8'h01, 8'h80, 8'hFF}, 16'd3);
    send_key('{8'h00}, 16'd1);
    drain();
  endtask

  task automatic test_each_mode();
    logic [1:0] modes[4] = '{MODE_WHOLE, MODE_HALF, MODE_TIMES33, MODE_UNUSED};
    foreach (modes[i]) begin
      configure(modes[i], '0);
      send_key('{8'hFF, 8'h00, 8'hA5}, 16'd3);
      drain();
    end
    configure(MODE_HALF, 32'd1000);
    send_key('{8'h7E}, 16'hFFFF);
    send_key('{8'h81}, 16'h0000);
    drain();
    configure(MODE_TIMES33, '1);
    send_key('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 16'd7);
    drain();
    configure(MODE_WHOLE, 32'd1);
    send_key('{8'h5A}, 16'd1);
    drain();
  endtask

  task automatic test_mode_change_mid_key();
    configure(MODE_WHOLE, TABLE_SIZE_RESET);
    send_key_byte(8'h11, 16'd5, 1'b0);
    send_key_byte(8'h22, 16'd5, 1'b0);
    send_key_byte(8'h33, 16'd5, 1'b0);
    drain();
    configure(MODE_TIMES33, 32'd997);
    send_key_byte(8'h44, 16'd5, 1'b0);
    send_key_byte(8'h55, 16'd5, 1'b1);
    drain();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
    int target;
    int sub_target;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    target = items_sent + n_items;
    while (items_sent < target) begin
      drain();
      if ($urandom_range(99) < 25) begin
        repeat ($urandom_range(1, 5))
          send_key_byte(BYTE_W'($urandom), LEN_W'($urandom), 1'b0);
        drain();
      end
      configure(2'($urandom_range(3)), pick_table_size());
      sub_target = items_sent + $urandom_range(80, 200);
      while (items_sent < sub_target && items_sent < target) begin
        send_random_key();
        if ($urandom_range(99) < 3) drain();
      end
    end
    drain();
  endtask

  initial begin
    rst        <= 1'b1;
    key_valid  <= 1'b0;
    key_byte   <= '0;
    key_length <= '0;
    last_byte  <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_HASH_MODE;
    cfg_data   <= '0;
    tx_idle_pct    = 12;
    rx_idle_pct    = 49;
    cur_mode       = MODE_WHOLE;
    cur_table_size = TABLE_SIZE_RESET;
    run_hash       = '0;
    run_count      = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_each_mode();
    test_mode_change_mid_key();
    test_random_traffic(12, 49, 570);
    test_random_traffic(49, 12, 570);
    test_random_traffic(0, 0, 570);
    if (errors == 0)
      $display("string_bucket_hash_engine_top_tb: PASS");
    else
      $display("string_bucket_hash_engine_top_tb: FAIL");
    $finish;
  end

endmodule
